>>> rtl/tem_pkg.sv
`default_nettype none
package tem_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_NODE    = 2'd0,
      CMD_WRITE_FEATURE = 2'd1,
      CMD_RUN           = 2'd2
   } command_type;

   localparam logic [1:0] CSR_TREE_COUNT    = 2'd0;
   localparam logic [1:0] CSR_CLASS_COUNT   = 2'd1;
   localparam logic [1:0] CSR_MISSING_VALUE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TREE,
      ST_FETCH,
      ST_NODE,
      ST_FEAT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               present;
      logic               leaf;
      logic [7:0]         feature;
      logic signed [31:0] value;
   } node_split_type;

   typedef struct packed {
      logic [7:0] yes_child;
      logic [7:0] no_child;
      logic [7:0] missing_child;
   } node_link_type;

   // shared controls for the row of margin cells
   typedef struct packed {
      logic               clear;
      logic               add;
      logic               shift;
      logic signed [31:0] weight;
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> rtl/tem_req_if.sv
`default_nettype none
interface tem_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [5:0]         tree_index;
   logic [7:0]         node_index;
   logic               node_present;
   logic               is_leaf;
   logic [7:0]         feature_index;
   logic signed [31:0] value;
   logic [7:0]         yes_child;
   logic [7:0]         no_child;
   logic [7:0]         missing_child;

   modport source (
      output valid, command, tree_index, node_index, node_present, is_leaf,
             feature_index, value, yes_child, no_child, missing_child,
      input  ready
   );
   modport sink (
      input  valid, command, tree_index, node_index, node_present, is_leaf,
             feature_index, value, yes_child, no_child, missing_child,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/tem_rsp_if.sv
`default_nettype none
interface tem_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         class_index;
   logic signed [31:0] margin;
   logic               last_class;

   modport source (
      output valid, class_index, margin, last_class,
      input  ready
   );
   modport sink (
      input  valid, class_index, margin, last_class,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/tem_ram.sv
`default_nettype none
module tem_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/tem_cell.sv
`default_nettype none
// One class margin: cleared per run, saturating accumulate, shift toward the output.
module tem_cell (
   input  wire logic                   clock,
   input  wire tem_pkg::cell_ctrl_type ctrl,
   input  wire logic                   hit,
   input  wire logic signed [31:0]     shift_data,
   output logic signed [31:0]          margin
);
   logic signed [31:0] margin_ff;
   logic signed [31:0] margin_in;
   logic signed [32:0] sum;

   always_comb begin
      sum = 33'(margin_ff) + 33'(ctrl.weight);
      margin_in = margin_ff;
      if (ctrl.clear) begin
         margin_in = '0;
      end else if (ctrl.add && hit) begin
         if (sum[32] != sum[31]) begin
            margin_in = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            margin_in = sum[31:0];
         end
      end else if (ctrl.shift) begin
         margin_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      margin_ff <= margin_in;
   end

   assign margin = margin_ff;
endmodule
`default_nettype wire

>>> rtl/tree_ensemble_margin_engine_top.sv
`default_nettype none
// Boosted decision-tree inference engine, Q16.16 fixed point.
// req_bus (valid/ready) carries command words: write node, write feature,
// run. Loads are taken while idle and produce nothing. A run walks trees
// 0 .. tree_count-1 from node 0, adds each reached leaf weight to class
// (tree mod class_count) and then sends one rsp_bus word per class, in
// class order, with last_class set on the final one.
// csr_* writes tree_count, class_count and missing_value; write only while
// the engine is idle.
// Walk: a tree step opens each tree; a split visit reads the node table,
// then the feature, then compares; a leaf or absent node ends the tree
// after the node table read. Emit sends one class word per cycle unless
// the receiver stalls. The walk is bound by the single node table read port.
// Margins live in a row of cells, one per class; the run clears them and
// the emit phase shifts them out of cell 0 toward the output register.
// req_bus.ready is high only while idle; the output register lets the next
// word be accepted while the last result still waits, and a stalled
// receiver simply holds the emit phase.
// Reset: after reset the split half of the node table is swept clear,
// with req_bus.ready low.
module tree_ensemble_margin_engine_top #(
   parameter int MAX_TREES      = 64,
   parameter int NODES_PER_TREE = 256,
   parameter int MAX_FEATURES   = 256,
   parameter int MAX_CLASSES    = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tem_req_if.sink          req_bus,
   tem_rsp_if.source        rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);
   // reachable sizes: field widths cap trees at 64, nodes and features at 256
   localparam int TREE_DEPTH = (MAX_TREES < 64) ? MAX_TREES : 64;
   localparam int NODE_DEPTH = (NODES_PER_TREE < 256) ? NODES_PER_TREE : 256;
   localparam int FEAT_DEPTH = (MAX_FEATURES < 256) ? MAX_FEATURES : 256;
   localparam int CELLS      = (MAX_CLASSES < 31) ? MAX_CLASSES : 31;
   localparam int NODE_TOTAL = TREE_DEPTH * NODE_DEPTH;
   localparam int NODE_AW    = (NODE_TOTAL > 1) ? $clog2(NODE_TOTAL) : 1;
   localparam int FAW        = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
   localparam int SW         = $clog2(NODES_PER_TREE + 1);
   localparam int SPLIT_W    = $bits(tem_pkg::node_split_type);
   localparam int LINK_W     = $bits(tem_pkg::node_link_type);

   // control state
   tem_pkg::state_type state_ff, state_in;
   logic [NODE_AW-1:0] clear_addr_ff, clear_addr_in;
   logic [6:0]         tree_ff, tree_in;
   logic [4:0]         cls_ff, cls_in;
   logic [7:0]         node_ff, node_in;
   logic [SW-1:0]      steps_ff, steps_in;
   logic [4:0]         emit_ff, emit_in;
   logic               feat_ok_ff, feat_ok_in;
   logic [FEAT_DEPTH-1:0] fvalid_ff, fvalid_in;

   // configuration
   logic [6:0]         tree_count_ff;
   logic [4:0]         class_count_ff;
   logic signed [31:0] missing_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_class_ff;
   logic signed [31:0] rsp_margin_ff;
   logic               rsp_last_ff;

   // memories
   logic               split_wr_en, link_wr_en, node_rd_en;
   logic [NODE_AW-1:0] split_wr_addr, node_wr_addr, walk_addr;
   tem_pkg::node_split_type split_wdata, split_rd;
   tem_pkg::node_link_type  link_wdata, link_rd;
   logic [SPLIT_W-1:0] split_rdata;
   logic [LINK_W-1:0]  link_rdata;
   logic               feat_wr_en, feat_rd_en;
   logic [31:0]        feat_rdata;

   // derived
   logic               req_fire, out_load, fetch_stop, tree_end, emit_last;
   logic [6:0]         trees_eff;
   logic [4:0]         classes_eff, classes_one;
   logic signed [31:0] feat_val;
   logic [7:0]         next_child;
   tem_pkg::command_type cmd;
   tem_pkg::cell_ctrl_type cell_ctrl;
   logic signed [31:0] chain [CELLS+1];

   assign req_bus.ready = (state_ff == tem_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign cmd           = tem_pkg::command_type'(req_bus.command);

   assign trees_eff   = (32'(tree_count_ff) > MAX_TREES) ? 7'(MAX_TREES) : tree_count_ff;
   assign classes_one = (class_count_ff == 5'd0) ? 5'd1 : class_count_ff;
   assign classes_eff = (32'(classes_one) > CELLS) ? 5'(CELLS) : classes_one;

   assign split_rd = tem_pkg::node_split_type'(split_rdata);
   assign link_rd  = tem_pkg::node_link_type'(link_rdata);

   assign walk_addr    = NODE_AW'(32'(tree_ff) * NODE_DEPTH + 32'(node_ff));
   assign node_wr_addr = NODE_AW'(32'(req_bus.tree_index) * NODE_DEPTH
                                 + 32'(req_bus.node_index));

   assign fetch_stop = (steps_ff == SW'(NODES_PER_TREE))
                       || (32'(node_ff) >= NODE_DEPTH)
                       || (32'(tree_ff) >= TREE_DEPTH);
   assign tree_end   = (tree_ff == trees_eff);
   assign out_load   = (state_ff == tem_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
   assign emit_last  = ((emit_ff + 5'd1) == classes_eff);

   // split compare: missing sentinel first, then signed threshold
   always_comb begin
      feat_val = feat_ok_ff ? feat_rdata : 32'sd0;
      if (feat_val == missing_ff) begin
         next_child = link_rd.missing_child;
      end else if (feat_val < split_rd.value) begin
         next_child = link_rd.yes_child;
      end else begin
         next_child = link_rd.no_child;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tem_pkg::ST_CLEAR: begin
            if (clear_addr_ff == NODE_AW'(NODE_TOTAL - 1)) begin
               state_in = tem_pkg::ST_IDLE;
            end
         end
         tem_pkg::ST_IDLE: begin
            if (req_fire && cmd == tem_pkg::CMD_RUN) begin
               state_in = tem_pkg::ST_TREE;
            end
         end
         tem_pkg::ST_TREE: begin
            state_in = tree_end ? tem_pkg::ST_EMIT : tem_pkg::ST_FETCH;
         end
         tem_pkg::ST_FETCH: begin
            state_in = fetch_stop ? tem_pkg::ST_TREE : tem_pkg::ST_NODE;
         end
         tem_pkg::ST_NODE: begin
            if (!split_rd.present || split_rd.leaf) begin
               state_in = tem_pkg::ST_TREE;
            end else begin
               state_in = tem_pkg::ST_FEAT;
            end
         end
         tem_pkg::ST_FEAT: begin
            state_in = tem_pkg::ST_FETCH;
         end
         tem_pkg::ST_EMIT: begin
            if (out_load && emit_last) begin
               state_in = tem_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tem_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath controls
   always_comb begin
      clear_addr_in = clear_addr_ff;
      tree_in       = tree_ff;
      cls_in        = cls_ff;
      node_in       = node_ff;
      steps_in      = steps_ff;
      emit_in       = emit_ff;
      feat_ok_in    = feat_ok_ff;
      fvalid_in     = fvalid_ff;
      split_wr_en   = 1'b0;
      link_wr_en    = 1'b0;
      split_wr_addr = node_wr_addr;
      split_wdata   = '{present: req_bus.node_present, leaf: req_bus.is_leaf,
                        feature: req_bus.feature_index, value: req_bus.value};
      link_wdata    = '{yes_child: req_bus.yes_child, no_child: req_bus.no_child,
                        missing_child: req_bus.missing_child};
      node_rd_en    = 1'b0;
      feat_wr_en    = 1'b0;
      feat_rd_en    = 1'b0;
      cell_ctrl     = '{clear: 1'b0, add: 1'b0, shift: 1'b0, weight: split_rd.value};
      case (state_ff)
         tem_pkg::ST_CLEAR: begin
            split_wr_en   = 1'b1;
            split_wr_addr = clear_addr_ff;
            split_wdata   = '0;
            clear_addr_in = clear_addr_ff + NODE_AW'(1);
         end
         tem_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  tem_pkg::CMD_WRITE_NODE: begin
                     if (32'(req_bus.tree_index) < TREE_DEPTH
                         && 32'(req_bus.node_index) < NODE_DEPTH) begin
                        split_wr_en = 1'b1;
                        link_wr_en  = 1'b1;
                     end
                  end
                  tem_pkg::CMD_WRITE_FEATURE: begin
                     if (32'(req_bus.node_index) < FEAT_DEPTH) begin
                        feat_wr_en = 1'b1;
                        fvalid_in[FAW'(req_bus.node_index)] = 1'b1;
                     end
                  end
                  tem_pkg::CMD_RUN: begin
                     tree_in         = '0;
                     cls_in          = '0;
                     cell_ctrl.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tem_pkg::ST_TREE: begin
            node_in  = '0;
            steps_in = '0;
            emit_in  = '0;
         end
         tem_pkg::ST_FETCH: begin
            if (fetch_stop) begin
               tree_in = tree_ff + 7'd1;
               cls_in  = ((cls_ff + 5'd1) == classes_eff) ? 5'd0 : cls_ff + 5'd1;
            end else begin
               node_rd_en = 1'b1;
               steps_in   = steps_ff + SW'(1);
            end
         end
         tem_pkg::ST_NODE: begin
            if (!split_rd.present || split_rd.leaf) begin
               cell_ctrl.add = split_rd.present;
               tree_in = tree_ff + 7'd1;
               cls_in  = ((cls_ff + 5'd1) == classes_eff) ? 5'd0 : cls_ff + 5'd1;
            end else begin
               feat_rd_en = 1'b1;
               feat_ok_in = (32'(split_rd.feature) < FEAT_DEPTH)
                            && fvalid_ff[FAW'(split_rd.feature)];
            end
         end
         tem_pkg::ST_FEAT: begin
            node_in = next_child;
         end
         tem_pkg::ST_EMIT: begin
            if (out_load) begin
               cell_ctrl.shift = 1'b1;
               emit_in = emit_ff + 5'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tem_pkg::ST_CLEAR;
         clear_addr_ff  <= '0;
         tree_ff        <= '0;
         cls_ff         <= '0;
         node_ff        <= '0;
         steps_ff       <= '0;
         emit_ff        <= '0;
         feat_ok_ff     <= 1'b0;
         fvalid_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         tree_count_ff  <= 7'd1;
         class_count_ff <= 5'd1;
         missing_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         tree_ff       <= tree_in;
         cls_ff        <= cls_in;
         node_ff       <= node_in;
         steps_ff      <= steps_in;
         emit_ff       <= emit_in;
         feat_ok_ff    <= feat_ok_in;
         fvalid_ff     <= fvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               tem_pkg::CSR_TREE_COUNT:    tree_count_ff  <= csr_wr_data[6:0];
               tem_pkg::CSR_CLASS_COUNT:   class_count_ff <= csr_wr_data[4:0];
               tem_pkg::CSR_MISSING_VALUE: missing_ff     <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_class_ff  <= emit_ff[3:0];
         rsp_margin_ff <= chain[0];
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.class_index = rsp_class_ff;
   assign rsp_bus.margin      = rsp_margin_ff;
   assign rsp_bus.last_class  = rsp_last_ff;

   // node table: split half is swept after reset, link half is written with it
   tem_ram #(.WIDTH(SPLIT_W), .DEPTH(NODE_TOTAL)) u_split_ram (
      .clock   (clock),
      .wr_en   (split_wr_en),
      .wr_addr (split_wr_addr),
      .wr_data (split_wdata),
      .rd_en   (node_rd_en),
      .rd_addr (walk_addr),
      .rd_data (split_rdata)
   );

   tem_ram #(.WIDTH(LINK_W), .DEPTH(NODE_TOTAL)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (link_wdata),
      .rd_en   (node_rd_en),
      .rd_addr (walk_addr),
      .rd_data (link_rdata)
   );

   // feature vector; slots never written read as zero via fvalid
   tem_ram #(.WIDTH(32), .DEPTH(FEAT_DEPTH)) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_wr_en),
      .wr_addr (FAW'(req_bus.node_index)),
      .wr_data (req_bus.value),
      .rd_en   (feat_rd_en),
      .rd_addr (FAW'(split_rd.feature)),
      .rd_data (feat_rdata)
   );

   // row of class margin cells; cell 0 feeds the output register
   assign chain[CELLS] = '0;
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tem_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .hit        (cls_ff == 5'(i)),
         .shift_data (chain[i+1]),
         .margin     (chain[i])
      );
   end
endmodule
`default_nettype wire

>>> verif/margin_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module margin_checker #(
   parameter int MAX_TREES      = 64,
   parameter int NODES_PER_TREE = 256,
   parameter int MAX_FEATURES   = 256,
   parameter int MAX_CLASSES    = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tem_req_if               req_bus,
   tem_rsp_if               rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data,
   output int               words_due,
   output int               fail_count
);

   localparam int NODE_TOTAL = MAX_TREES * NODES_PER_TREE;

   typedef struct {
      logic [3:0]         class_index;
      logic signed [31:0] margin;
      logic               last_class;
   } margin_word_type;

   tem_pkg::node_split_type split_tab[NODE_TOTAL];
   tem_pkg::node_link_type  link_tab[NODE_TOTAL];
   logic signed [31:0] feature_tab[MAX_FEATURES];
   logic [6:0]         tree_count;
   logic [4:0]         class_count;
   logic signed [31:0] missing_value;
   margin_word_type    margin_q[$];

   initial fail_count = 0;

   function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647) return 32'sh7fffffff;
      if (s < -64'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   // walk one tree from node 0; 1 and the leaf weight when a leaf is reached
   function automatic bit walk_tree(int t, output logic signed [31:0] w);
      int                 node;
      int                 at;
      logic signed [31:0] f;
      node = 0;
      w = '0;
      for (int step = 0; step < NODES_PER_TREE; step++) begin
         if (node >= NODES_PER_TREE) return 0;
         at = t * NODES_PER_TREE + node;
         if (!split_tab[at].present) return 0;
         if (split_tab[at].leaf) begin
            w = split_tab[at].value;
            return 1;
         end
         f = (split_tab[at].feature < MAX_FEATURES) ? feature_tab[split_tab[at].feature] : '0;
         if (f == missing_value) node = int'(link_tab[at].missing_child);
         else if (f < split_tab[at].value) node = int'(link_tab[at].yes_child);
         else node = int'(link_tab[at].no_child);
      end
      return 0;
   endfunction

   function automatic void predict_run();
      int                 trees;
      int                 classes;
      logic signed [31:0] sums[MAX_CLASSES];
      logic signed [31:0] w;
      margin_word_type    m;
      trees = (tree_count > MAX_TREES) ? MAX_TREES : int'(tree_count);
      classes = (class_count == 0) ? 1 : int'(class_count);
      if (classes > MAX_CLASSES) classes = MAX_CLASSES;
      foreach (sums[k]) sums[k] = '0;
      for (int t = 0; t < trees; t++) begin
         if (walk_tree(t, w)) sums[t % classes] = sat_add(sums[t % classes], w);
      end
      for (int k = 0; k < classes; k++) begin
         m.class_index = k[3:0];
         m.margin = sums[k];
         m.last_class = (k + 1 == classes);
         margin_q.insert(margin_q.size(), m);
      end
   endfunction

   function automatic void apply_word();
      int at;
      case (req_bus.command)
         tem_pkg::CMD_WRITE_NODE: begin
            if (req_bus.tree_index < MAX_TREES && req_bus.node_index < NODES_PER_TREE) begin
               at = req_bus.tree_index * NODES_PER_TREE + req_bus.node_index;
               split_tab[at].present = req_bus.node_present;
               split_tab[at].leaf = req_bus.is_leaf;
               split_tab[at].feature = req_bus.feature_index;
               split_tab[at].value = req_bus.value;
               link_tab[at].yes_child = req_bus.yes_child;
               link_tab[at].no_child = req_bus.no_child;
               link_tab[at].missing_child = req_bus.missing_child;
            end
         end
         tem_pkg::CMD_WRITE_FEATURE: begin
            if (req_bus.node_index < MAX_FEATURES) feature_tab[req_bus.node_index] = req_bus.value;
         end
         tem_pkg::CMD_RUN: predict_run();
         default: ;
      endcase
   endfunction

   function automatic void check_word();
      margin_word_type e;
      if (margin_q.size() == 0) begin
         $display("%0t: unexpected margin word class=%0d margin=%0d last=%0b", $time,
                  rsp_bus.class_index, rsp_bus.margin, rsp_bus.last_class);
         fail_count++;
         return;
      end
      e = margin_q.pop_front();
      if (rsp_bus.class_index !== e.class_index) begin
         $display("%0t: class_index expected %0d actual %0d", $time, e.class_index,
                  rsp_bus.class_index);
         fail_count++;
      end
      if (rsp_bus.margin !== e.margin) begin
         $display("%0t: margin (class %0d) expected %0d actual %0d", $time, e.class_index,
                  e.margin, rsp_bus.margin);
         fail_count++;
      end
      if (rsp_bus.last_class !== e.last_class) begin
         $display("%0t: last_class (class %0d) expected %0b actual %0b", $time,
                  e.class_index, e.last_class, rsp_bus.last_class);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (split_tab[i]) begin
            split_tab[i] = '0;
            link_tab[i] = '0;
         end
         foreach (feature_tab[i]) feature_tab[i] = '0;
         tree_count = 7'd1;
         class_count = 5'd1;
         missing_value = '0;
         margin_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               tem_pkg::CSR_TREE_COUNT:    tree_count = csr_wr_data[6:0];
               tem_pkg::CSR_CLASS_COUNT:   class_count = csr_wr_data[4:0];
               tem_pkg::CSR_MISSING_VALUE: missing_value = csr_wr_data;
               default: ;
            endcase
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) apply_word();
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_word();
      end
      words_due <= margin_q.size();
   end

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int CYCLE_LIMIT = 100000000;
   localparam int SETTLE      = 40;   // idle cycles after the last margin word
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   // one command word as the driver sees it
   typedef struct {
      logic [1:0]         command;
      logic [5:0]         tree_index;
      logic [7:0]         node_index;
      logic               node_present;
      logic               is_leaf;
      logic [7:0]         feature_index;
      logic signed [31:0] value;
      logic [7:0]         yes_child;
      logic [7:0]         no_child;
      logic [7:0]         missing_child;
   } cmd_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wr_data = '0;
   int          words_due;
   int          fail_count;
   int          cycles = 0;
   int          burst_left = 0;

   // shadow of the current settings, used to aim random stimulus
   int                 cur_trees = 1;
   logic signed [31:0] cur_missing = '0;

   tem_req_if req_bus ();
   tem_rsp_if rsp_bus ();

   tree_ensemble_margin_engine_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   margin_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .words_due   (words_due),
      .fail_count  (fail_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[tree_ensemble_margin_engine_top] ERROR");
         $finish;
      end
   end

   // receiver back-pressure: mode changes every so often
   int stall_tick = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;                           // free running
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= ($urandom_range(0, 9) == 0);    // heavy stall
         default: rsp_bus.ready <= stall_tick[3];            // long on/off runs
      endcase
   end

   // drive one word and hold it until taken; sender idles in bursts
   task automatic push(cmd_word_type w);
      req_bus.valid <= 1'b1;
      req_bus.command <= w.command;
      req_bus.tree_index <= w.tree_index;
      req_bus.node_index <= w.node_index;
      req_bus.node_present <= w.node_present;
      req_bus.is_leaf <= w.is_leaf;
      req_bus.feature_index <= w.feature_index;
      req_bus.value <= w.value;
      req_bus.yes_child <= w.yes_child;
      req_bus.no_child <= w.no_child;
      req_bus.missing_child <= w.missing_child;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end
   endtask

   // drop valid and wait until every margin word is in, plus the engine's tail
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // all three registers, back to back; engine must be idle
   task automatic write_settings(logic [6:0] trees, logic [4:0] classes, logic [31:0] miss);
      csr_wr_en <= 1'b1;
      csr_index <= tem_pkg::CSR_TREE_COUNT;
      csr_wr_data <= {25'd0, trees};
      @(posedge clock);
      csr_index <= tem_pkg::CSR_CLASS_COUNT;
      csr_wr_data <= {27'd0, classes};
      @(posedge clock);
      csr_index <= tem_pkg::CSR_MISSING_VALUE;
      csr_wr_data <= miss;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_trees = (trees > 64) ? 64 : int'(trees);
      cur_missing = miss;
   endtask

   function automatic cmd_word_type node_word(int t, int n, bit present, bit leaf, int feat,
                                              logic [31:0] v, int yes, int no, int miss);
      cmd_word_type w;
      w.command = tem_pkg::CMD_WRITE_NODE;
      w.tree_index = 6'(t);
      w.node_index = 8'(n);
      w.node_present = present;
      w.is_leaf = leaf;
      w.feature_index = 8'(feat);
      w.value = v;
      w.yes_child = 8'(yes);
      w.no_child = 8'(no);
      w.missing_child = 8'(miss);
      return w;
   endfunction

   function automatic cmd_word_type feature_word(int slot, logic [31:0] v);
      cmd_word_type w;
      w = node_word(0, slot, 0, 0, 0, v, 0, 0, 0);
      w.command = tem_pkg::CMD_WRITE_FEATURE;
      return w;
   endfunction

   function automatic cmd_word_type run_word();
      cmd_word_type w;
      w = node_word($urandom_range(0, 63), $urandom_range(0, 255), 1, 1, 0, $urandom, 0, 0, 0);
      w.command = tem_pkg::CMD_RUN;
      return w;
   endfunction

   // Q16.16 values near the interesting range, the current missing value, or fully random bits
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return cur_missing;
         default: return $signed($urandom_range(0, 16) - 8) <<< 15;
      endcase
   endfunction

   function automatic cmd_word_type random_word();
      cmd_word_type w;
      int           t;
      int           n;
      int           roll;
      roll = $urandom_range(0, 99);
      w = run_word();
      w.value = $urandom;
      w.feature_index = 8'($urandom);
      w.yes_child = 8'($urandom);
      w.no_child = 8'($urandom);
      w.missing_child = 8'($urandom);
      w.node_present = 1'($urandom_range(0, 1));
      w.is_leaf = 1'($urandom_range(0, 1));
      if (roll < 3) begin
         w.command = CMD_UNKNOWN;                       // ignored command
      end else if (roll < 23) begin
         w.command = tem_pkg::CMD_RUN;
      end else if (roll < 45) begin
         w.command = tem_pkg::CMD_WRITE_FEATURE;
         if ($urandom_range(0, 7) != 0) w.node_index = 8'($urandom_range(0, 7));
         w.value = pick_value();
      end else begin
         // mostly well-formed heap-shaped trees: children below, features 0..7
         t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                         : $urandom_range(0, (cur_trees > 0) ? cur_trees - 1 : 0);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 14);
         w.command = tem_pkg::CMD_WRITE_NODE;
         w.tree_index = 6'(t);
         w.node_index = 8'(n);
         w.node_present = ($urandom_range(0, 9) != 0);
         w.is_leaf = (n >= 7) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 2) == 0);
         w.value = pick_value();
         if ($urandom_range(0, 9) != 0) begin
            w.feature_index = 8'($urandom_range(0, 7));
            w.yes_child = 8'(2 * n + 1);
            w.no_child = 8'(2 * n + 2);
            w.missing_child = 8'(2 * n + $urandom_range(1, 2));
         end
      end
      return w;
   endfunction

   task automatic directed();
      write_settings(7'd4, 5'd2, 32'h1234_5678);
      push(feature_word(3, 32'h0001_0000));
      push(feature_word(255, 32'h8000_0000));
      push(feature_word(0, 32'h7fff_ffff));
      // tree 0: split on feature 3, leaves on each branch
      push(node_word(0, 0, 1, 0, 3, 32'h0002_0000, 1, 2, 3));
      push(node_word(0, 1, 1, 1, 0, 32'd100, 0, 0, 0));
      push(node_word(0, 2, 1, 1, 0, -32'sd5, 0, 0, 0));
      push(node_word(0, 3, 1, 1, 0, 32'd7, 0, 0, 0));
      // tree 1: most negative feature goes yes into a removed node
      push(node_word(1, 0, 1, 0, 255, 32'h0, 5, 255, 0));
      push(node_word(1, 5, 0, 1, 255, 32'hffff_ffff, 255, 255, 255));
      // tree 2: split that loops on itself, walk runs out of steps
      push(node_word(2, 0, 1, 0, 0, 32'h0, 0, 0, 0));
      // tree 3: largest weight
      push(node_word(3, 0, 1, 1, 0, 32'h7fff_ffff, 0, 0, 0));
      push(run_word());
      push(node_word(0, 0, 1, 0, 3, 32'h0002_0000, 1, 2, 3));  // unchanged rewrite
      push(feature_word(3, 32'h1234_5678));                      // feature is missing
      push(run_word());
      push(feature_word(3, 32'h0002_0000));                      // equal to threshold
      push(run_word());
      drain();
      // too many trees, zero classes: margins pile into class 0, saturate high, then low
      write_settings(7'd127, 5'd0, 32'h0);
      push(node_word(4, 0, 1, 1, 0, 32'h7fff_ffff, 0, 0, 0));
      push(node_word(63, 255, 1, 1, 255, 32'h8000_0000, 255, 255, 255));
      push(node_word(63, 0, 1, 1, 0, 32'h8000_0000, 0, 0, 0));
      push(node_word(47, 0, 1, 1, 0, 32'h8000_0000, 0, 0, 0));
      push(run_word());
      drain();
      // full class count: classes 15 collects the two most negative leaves
      write_settings(7'd64, 5'd16, 32'h8000_0000);
      push(run_word());
      drain();
      write_settings(7'd0, 5'd31, 32'h7fff_ffff);                 // no trees, capped classes
      push(run_word());
      drain();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.tree_index = '0;
      req_bus.node_index = '0;
      req_bus.node_present = 1'b0;
      req_bus.is_leaf = 1'b0;
      req_bus.feature_index = '0;
      req_bus.value = '0;
      req_bus.yes_child = '0;
      req_bus.no_child = '0;
      req_bus.missing_child = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      // random phases, each under fresh settings
      for (int phase = 0; phase < 8; phase++) begin
         logic [6:0]  trees;
         logic [4:0]  classes;
         logic [31:0] miss;
         trees = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(64, 127))
                                             : 7'($urandom_range(0, 16));
         classes = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 4));
         miss = ($urandom_range(0, 1) == 0) ? $urandom : ($signed($urandom_range(0, 16) - 8) <<< 15);
         write_settings(trees, classes, miss);
         repeat (50) push(random_word());
         drain();
      end
      if (fail_count == 0) begin
         $display("[tree_ensemble_margin_engine_top] OK");
      end else begin
         $display("[tree_ensemble_margin_engine_top] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/tem_pkg.sv
rtl/tem_req_if.sv
rtl/tem_rsp_if.sv
rtl/tem_ram.sv
rtl/tem_cell.sv
rtl/tree_ensemble_margin_engine_top.sv
verif/margin_checker.sv
verif/tb.sv
